// ----- rtl/sbs_pkg.sv -----
// Package for the backtracking puzzle solver: grid geometry and helper types.
// No dependencies.
`default_nettype none
package sbs_pkg;
    localparam int BOX_SIDE  = 3;
    localparam int SIDE      = BOX_SIDE * BOX_SIDE;
    localparam int ROW_W     = 36;
    localparam int CELL_W    = 4;
    localparam int ROWIDX_W  = 4;
    localparam int COLIDX_W  = 4;
    localparam int CURSOR_W  = 7;
    localparam int CELLS     = SIDE * SIDE;

    typedef logic [CELL_W-1:0] cell_t;
    typedef logic [ROWIDX_W-1:0] ridx_t;
    typedef logic [ROW_W-1:0] row_t;

    // one grid row: digit and given flag per position
    typedef struct packed {
        logic [SIDE-1:0][CELL_W-1:0] val;
        logic [SIDE-1:0]             given;
    } grow_t;
endpackage
`default_nettype wire

// ----- rtl/sudoku_backtracking_solver.sv -----
// Top level of the backtracking puzzle solver: load, search sequencer, output.
// Depends on sbs_pkg and sbs_row_ram.
//
//  channel  | dir | tdata                 | tuser / tlast
//  s_axis   | in  | row_cells[35:0]       | tlast = last_row
//  m_axis   | out | row_cells_res[35:0]   | tuser[0] = solved, tlast = last_result
//
// Rows load one per cycle while s_axis_tready is high. After the last row the
// row store is scanned once to build digit masks per row, column and box,
// kept apart for givens and for searched cells. Each cursor step reads the
// cell's row (S_SRD), then picks the next free digit and writes the row back
// (S_SEX); the write lands before the next read, so no forwarding is needed.
// Results are read out of the row store row by row (S_ORD, S_OSEND) into an
// output register; m_axis_tready stalls both that register and the readout.
// A failure item is loaded in S_OSEND after the search gives up. s_axis_tready
// stays low from the last row until the final result is in the output register.
// Reset clears control state; the row store and the masks have no reset.
`default_nettype none
module sudoku_backtracking_solver (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,   // row_cells[35:0], zero pad
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // row_cells_res[35:0], zero pad
    output logic [0:0]       m_axis_tuser,   // solved
    output logic             m_axis_tlast
);
    import sbs_pkg::*;

    typedef enum logic [2:0] {S_LOAD, S_FETCH, S_SRD, S_SEX, S_ORD, S_OSEND} st_t;
    typedef logic [SIDE:1] dmask_t;     // one bit per digit

    st_t st_reg;

    ridx_t load_row_count_reg;
    logic [CURSOR_W-1:0] search_cursor_reg;
    ridx_t pr_reg;                      // cursor row
    logic [COLIDX_W-1:0] pc_reg;        // cursor column
    logic fwd_reg;
    logic ok_reg;
    ridx_t rd_reg;          // rows requested counter
    logic  rvalid_reg;
    ridx_t rrow_reg;

    // digits held by givens (gv_) and by searched cells (sc_)
    dmask_t gv_row_reg [SIDE];
    dmask_t gv_col_reg [SIDE];
    dmask_t gv_box_reg [SIDE];
    dmask_t sc_row_reg [SIDE];
    dmask_t sc_col_reg [SIDE];
    dmask_t sc_box_reg [SIDE];

    logic   we;
    ridx_t  waddr, raddr;
    grow_t  wdata, rdata;

    sbs_row_ram u_ram (.aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
                       .raddr(raddr), .rdata(rdata));

    function automatic dmask_t digit_bit(cell_t v);
        dmask_t m;
        for (int d = 1; d <= SIDE; d++) m[d] = (v == CELL_W'(d));
        return m;
    endfunction

    // band (or stack) of a row (or column) index
    function automatic ridx_t band_of(ridx_t i);
        ridx_t b;
        b = '0;
        for (int k = 1; k < BOX_SIDE; k++)
            if (32'(i) >= k * BOX_SIDE) b = ridx_t'(k);
        return b;
    endfunction

    wire s_acc = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (st_reg == S_LOAD);

    // current cell, read in S_SRD and valid in the state after it (S_SEX)
    cell_t  cur_val;
    logic   cur_given;
    ridx_t  cur_box;
    dmask_t own, used;
    cell_t  start, pick;
    logic   found;
    logic   step_fwd, step_back, give_up;
    always_comb begin
        cur_val   = rdata.val[pc_reg];
        cur_given = rdata.given[pc_reg];
        cur_box   = ridx_t'(32'(band_of(pr_reg)) * BOX_SIDE + 32'(band_of(pc_reg)));
        // searched digits are unique in their units, so dropping our own is exact
        own  = digit_bit(cur_val);
        used = gv_row_reg[pr_reg] | gv_col_reg[pc_reg] | gv_box_reg[cur_box]
             | ((sc_row_reg[pr_reg] | sc_col_reg[pc_reg] | sc_box_reg[cur_box]) & ~own);
        start = fwd_reg ? CELL_W'(1) : cur_val + 1'b1;
        pick  = '0;
        found = 1'b0;
        for (int d = SIDE; d >= 1; d--) begin
            if (!used[d] && CELL_W'(d) >= start) begin
                pick = CELL_W'(d);
                found = 1'b1;
            end
        end
        step_fwd  = 1'b0;
        step_back = 1'b0;
        give_up   = 1'b0;
        if (cur_given && fwd_reg) step_fwd = 1'b1;
        else if (!cur_given && found) step_fwd = 1'b1;
        else if (search_cursor_reg == '0) give_up = 1'b1;
        else step_back = 1'b1;
    end

    // masks contributed by one fetched row
    dmask_t f_row_g, f_row_s;
    dmask_t f_col_g [SIDE];
    dmask_t f_col_s [SIDE];
    dmask_t f_box_g [BOX_SIDE];
    dmask_t f_box_s [BOX_SIDE];
    always_comb begin
        f_row_g = '0;
        f_row_s = '0;
        for (int b = 0; b < BOX_SIDE; b++) begin
            f_box_g[b] = '0;
            f_box_s[b] = '0;
        end
        for (int c = 0; c < SIDE; c++) begin
            f_col_g[c] = rdata.given[c] ? digit_bit(rdata.val[c]) : '0;
            f_col_s[c] = rdata.given[c] ? '0 : digit_bit(rdata.val[c]);
            f_row_g = f_row_g | f_col_g[c];
            f_row_s = f_row_s | f_col_s[c];
            f_box_g[c / BOX_SIDE] = f_box_g[c / BOX_SIDE] | f_col_g[c];
            f_box_s[c / BOX_SIDE] = f_box_s[c / BOX_SIDE] | f_col_s[c];
        end
    end

    // memory ports
    grow_t in_row, upd_row;
    always_comb begin
        for (int c = 0; c < SIDE; c++) begin
            in_row.val[c]   = s_axis_tdata[CELL_W*c +: CELL_W];
            in_row.given[c] = (s_axis_tdata[CELL_W*c +: CELL_W] != '0);
        end
        upd_row = rdata;
        upd_row.val[pc_reg] = found ? pick : '0;
        we = 1'b0; waddr = load_row_count_reg; wdata = in_row;
        if (st_reg == S_LOAD) begin
            we = s_acc && (32'(load_row_count_reg) < SIDE);
        end else if (st_reg == S_SEX && !cur_given) begin
            we = 1'b1;
            waddr = pr_reg;
            wdata = upd_row;
        end
        raddr = (st_reg == S_SRD) ? pr_reg : rd_reg;
    end

    wire out_free = !m_axis_tvalid || m_axis_tready;
    wire out_load = (st_reg == S_OSEND) && out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_LOAD;
            load_row_count_reg <= '0;
            search_cursor_reg <= '0;
            pr_reg <= '0;
            pc_reg <= '0;
            fwd_reg <= 1'b1;
            ok_reg <= 1'b0;
            rd_reg <= '0;
            rvalid_reg <= 1'b0;
            rrow_reg <= '0;
            m_axis_tvalid <= 1'b0;
        end else begin
            if (out_load) m_axis_tvalid <= 1'b1;
            else if (m_axis_tready) m_axis_tvalid <= 1'b0;
            if (out_load) begin
                m_axis_tdata <= ok_reg ? 40'(rdata.val) : '0;
                m_axis_tuser <= ok_reg;
                m_axis_tlast <= !ok_reg || (32'(rd_reg) == SIDE-1);
            end
            case (st_reg)
                S_LOAD: begin
                    if (s_acc) begin
                        if (s_axis_tlast) begin
                            st_reg <= S_FETCH;
                            load_row_count_reg <= '0;
                            rd_reg <= '0;
                            rvalid_reg <= 1'b0;
                            for (int k = 0; k < SIDE; k++) begin
                                gv_row_reg[k] <= '0; gv_col_reg[k] <= '0; gv_box_reg[k] <= '0;
                                sc_row_reg[k] <= '0; sc_col_reg[k] <= '0; sc_box_reg[k] <= '0;
                            end
                        end else if (32'(load_row_count_reg) < SIDE) begin
                            load_row_count_reg <= load_row_count_reg + 1'b1;
                        end
                    end
                end
                S_FETCH: begin
                    // scan all rows into the masks; the row read is registered
                    rvalid_reg <= (32'(rd_reg) < SIDE);
                    rrow_reg <= rd_reg;
                    if (32'(rd_reg) < SIDE) rd_reg <= rd_reg + 1'b1;
                    if (rvalid_reg) begin
                        gv_row_reg[rrow_reg] <= f_row_g;
                        sc_row_reg[rrow_reg] <= f_row_s;
                        for (int c = 0; c < SIDE; c++) begin
                            gv_col_reg[c] <= gv_col_reg[c] | f_col_g[c];
                            sc_col_reg[c] <= sc_col_reg[c] | f_col_s[c];
                        end
                        for (int b = 0; b < BOX_SIDE; b++) begin
                            gv_box_reg[ridx_t'(32'(band_of(rrow_reg)) * BOX_SIDE + b)] <=
                                gv_box_reg[ridx_t'(32'(band_of(rrow_reg)) * BOX_SIDE + b)]
                                | f_box_g[b];
                            sc_box_reg[ridx_t'(32'(band_of(rrow_reg)) * BOX_SIDE + b)] <=
                                sc_box_reg[ridx_t'(32'(band_of(rrow_reg)) * BOX_SIDE + b)]
                                | f_box_s[b];
                        end
                        if (32'(rrow_reg) == SIDE-1) begin
                            st_reg <= S_SRD;
                            search_cursor_reg <= '0;
                            pr_reg <= '0;
                            pc_reg <= '0;
                            fwd_reg <= 1'b1;
                        end
                    end
                end
                S_SRD: begin
                    if (32'(search_cursor_reg) >= CELLS) begin
                        ok_reg <= 1'b1; st_reg <= S_ORD; rd_reg <= '0;
                    end else st_reg <= S_SEX;
                end
                S_SEX: begin
                    if (give_up) begin
                        ok_reg <= 1'b0; st_reg <= S_OSEND;
                    end else st_reg <= S_SRD;
                    if (step_fwd) begin
                        search_cursor_reg <= search_cursor_reg + 1'b1;
                        if (32'(pc_reg) == SIDE-1) begin
                            pc_reg <= '0; pr_reg <= pr_reg + 1'b1;
                        end else pc_reg <= pc_reg + 1'b1;
                    end
                    if (step_back) begin
                        search_cursor_reg <= search_cursor_reg - 1'b1;
                        if (pc_reg == '0) begin
                            pc_reg <= COLIDX_W'(SIDE-1); pr_reg <= pr_reg - 1'b1;
                        end else pc_reg <= pc_reg - 1'b1;
                    end
                    if (!cur_given) begin
                        // own digit leaves the masks, the picked one (if any) enters
                        fwd_reg <= found;
                        sc_row_reg[pr_reg] <= (sc_row_reg[pr_reg] & ~own)
                                              | (found ? digit_bit(pick) : '0);
                        sc_col_reg[pc_reg] <= (sc_col_reg[pc_reg] & ~own)
                                              | (found ? digit_bit(pick) : '0);
                        sc_box_reg[cur_box] <= (sc_box_reg[cur_box] & ~own)
                                               | (found ? digit_bit(pick) : '0);
                    end
                end
                S_ORD: begin
                    st_reg <= S_OSEND;
                end
                S_OSEND: begin
                    if (out_free) begin
                        if (!ok_reg || 32'(rd_reg) == SIDE-1) begin
                            rd_reg <= '0; st_reg <= S_LOAD;
                        end else begin
                            rd_reg <= rd_reg + 1'b1; st_reg <= S_ORD;
                        end
                    end
                end
                default: st_reg <= S_LOAD;
            endcase
        end
    end

    ap_no_in_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tready |-> (st_reg == S_LOAD)) else $error("ready while busy");
    ap_fail_single: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tlast) else $error("bad fail item");
    ap_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tlast))) else $error("output changed while stalled");
    ap_cursor: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_reg == S_SRD || st_reg == S_SEX) |-> (32'(search_cursor_reg) <= CELLS))
        else $error("cursor");
    ap_cursor_rc: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(search_cursor_reg) == 32'(pr_reg) * SIDE + 32'(pc_reg))
        else $error("cursor row/column out of step");
endmodule
`default_nettype wire

// ----- rtl/sbs_row_ram.sv -----
// Row-wide grid store: one row per entry, digits and given flags.
// Depends on sbs_pkg.
`default_nettype none
module sbs_row_ram (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire sbs_pkg::ridx_t waddr,
    input  wire sbs_pkg::grow_t wdata,
    input  wire sbs_pkg::ridx_t raddr,
    output sbs_pkg::grow_t     rdata
);
    import sbs_pkg::*;
    grow_t mem [SIDE];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking bench for sudoku_backtracking_solver: loads puzzles row by row over s_axis
// and checks every m_axis result against an in-bench depth-first search of the same grid.
// Depends on sbs_pkg and the solver RTL.
`timescale 1ns / 100ps
module tb_top;
    import sbs_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;   // row_cells[35:0], zero pad
    logic        s_axis_tlast = 1'b0; // last_row
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;        // row_cells_res[35:0], zero pad
    logic [0:0]  m_axis_tuser;        // solved
    logic        m_axis_tlast;        // last_result

    always #5 aclk = ~aclk;

    sudoku_backtracking_solver dut (.*);

    // one expected result row
    typedef struct {
        row_t cells;
        bit   solved;
        bit   last;
    } solve_row_t;

    solve_row_t solve_q[$];
    int  errors = 0;
    int  rows_sent = 0, rows_seen = 0, puzzles = 0, unsolvable = 0;
    bit  calm = 1'b0;   // no idling on either side while set

    // predictor state: working grid, given flags and load pointer
    cell_t work_grid[CELLS];
    bit    fixed_cell[CELLS];
    int    load_row = 0;

    function automatic bit digit_ok(int pos, int d);
        int r, c, br, bc;
        r = pos / SIDE;
        c = pos % SIDE;
        for (int k = 0; k < SIDE; k++)
            if (work_grid[r*SIDE+k] == d || work_grid[k*SIDE+c] == d) return 1'b0;
        br = (r / BOX_SIDE) * BOX_SIDE;
        bc = (c / BOX_SIDE) * BOX_SIDE;
        for (int y = br; y < br + BOX_SIDE; y++)
            for (int x = bc; x < bc + BOX_SIDE; x++)
                if (work_grid[y*SIDE+x] == d) return 1'b0;
        return 1'b1;
    endfunction

    function automatic bit search_grid();
        int  pos, d, first;
        bit  fwd;
        pos = 0;
        fwd = 1'b1;
        while (pos < CELLS) begin
            if (fixed_cell[pos]) begin
                if (fwd) pos++;
                else if (pos == 0) return 1'b0;
                else pos--;
            end else begin
                first = fwd ? 1 : int'(work_grid[pos]) + 1;
                work_grid[pos] = '0;
                for (d = first; d <= SIDE; d++)
                    if (digit_ok(pos, d)) break;
                if (d <= SIDE) begin
                    work_grid[pos] = cell_t'(d);
                    pos++;
                    fwd = 1'b1;
                end else if (pos == 0) begin
                    return 1'b0;
                end else begin
                    pos--;
                    fwd = 1'b0;
                end
            end
        end
        return 1'b1;
    endfunction

    // model one accepted row; queue the results it causes
    function automatic void predict_row(row_t cells, bit last);
        solve_row_t e;
        if (load_row < SIDE) begin
            for (int c = 0; c < SIDE; c++) begin
                work_grid[load_row*SIDE+c] = cells[4*c +: 4];
                fixed_cell[load_row*SIDE+c] = (cells[4*c +: 4] != 0);
            end
            load_row++;
        end
        if (!last) return;
        load_row = 0;
        puzzles++;
        if (!search_grid()) begin
            unsolvable++;
            e.cells = '0; e.solved = 1'b0; e.last = 1'b1;
            solve_q.push_back(e);
            return;
        end
        for (int r = 0; r < SIDE; r++) begin
            e.cells = '0;
            for (int c = 0; c < SIDE; c++) e.cells[4*c +: 4] = work_grid[r*SIDE+c];
            e.solved = 1'b1;
            e.last = (r == SIDE - 1);
            solve_q.push_back(e);
        end
    endfunction

    // send one row; tvalid is only lowered in an idle cycle
    task automatic send_row(row_t cells, bit last);
        while (!calm && $urandom_range(99) < 20) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, cells};
        s_axis_tlast  <= last;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        rows_sent++;
        predict_row(cells, last);
    endtask

    // result side: random back-pressure, then compare with oldest expectation
    always @(posedge aclk) begin
        if (m_axis_tvalid && m_axis_tready && aresetn) begin
            rows_seen++;
            if (solve_q.size() == 0) begin
                $error("result item with nothing expected: cells %h", m_axis_tdata);
                errors++;
            end else begin
                solve_row_t e;
                e = solve_q.pop_front();
                if (m_axis_tdata[35:0] !== e.cells) begin
                    $error("row_cells_res: expected %h, got %h", e.cells, m_axis_tdata[35:0]);
                    errors++;
                end
                if (m_axis_tuser[0] !== e.solved) begin
                    $error("solved: expected %0b, got %0b", e.solved, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tlast !== e.last) begin
                    $error("last_result: expected %0b, got %0b", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
        m_axis_tready <= aresetn && (calm || $urandom_range(99) >= 20);
    end

    // random valid grid: base pattern, then digit relabel and row/column shuffles
    function automatic void make_solution(output cell_t g[CELLS]);
        int perm[SIDE], rmap[SIDE], cmap[SIDE], band[BOX_SIDE], stk[BOX_SIDE];
        int j, t;
        for (int i = 0; i < SIDE; i++) perm[i] = i + 1;
        for (int i = SIDE - 1; i > 0; i--) begin
            j = $urandom_range(i); t = perm[i]; perm[i] = perm[j]; perm[j] = t;
        end
        for (int i = 0; i < BOX_SIDE; i++) begin band[i] = i; stk[i] = i; end
        for (int i = BOX_SIDE - 1; i > 0; i--) begin
            j = $urandom_range(i); t = band[i]; band[i] = band[j]; band[j] = t;
            j = $urandom_range(i); t = stk[i]; stk[i] = stk[j]; stk[j] = t;
        end
        for (int b = 0; b < BOX_SIDE; b++) begin
            int rr[BOX_SIDE], cc[BOX_SIDE];
            for (int i = 0; i < BOX_SIDE; i++) begin rr[i] = i; cc[i] = i; end
            for (int i = BOX_SIDE - 1; i > 0; i--) begin
                j = $urandom_range(i); t = rr[i]; rr[i] = rr[j]; rr[j] = t;
                j = $urandom_range(i); t = cc[i]; cc[i] = cc[j]; cc[j] = t;
            end
            for (int i = 0; i < BOX_SIDE; i++) begin
                rmap[b*BOX_SIDE+i] = band[b]*BOX_SIDE + rr[i];
                cmap[b*BOX_SIDE+i] = stk[b]*BOX_SIDE + cc[i];
            end
        end
        for (int r = 0; r < SIDE; r++)
            for (int c = 0; c < SIDE; c++)
                g[r*SIDE+c] = cell_t'(perm[(rmap[r]*BOX_SIDE + rmap[r]/BOX_SIDE + cmap[c]) % SIDE]);
    endfunction

    function automatic void blank_cells(ref cell_t g[CELLS], input int n);
        for (int i = 0; i < n; i++) g[$urandom_range(CELLS-1)] = '0;
    endfunction

    function automatic row_t grid_row(const ref cell_t g[CELLS], input int r);
        row_t v = '0;
        for (int c = 0; c < SIDE; c++) v[4*c +: 4] = g[r*SIDE+c];
        return v;
    endfunction

    // load rows 0..SIDE-1 then the extra rows; last marks the final row sent
    task automatic send_grid(cell_t g[CELLS], int extra = 0);
        for (int r = 0; r < SIDE; r++) send_row(grid_row(g, r), 1'b0 ? 1'b0 : (r == SIDE-1 && extra == 0));
        for (int i = 0; i < extra; i++) send_row(row_t'({$urandom, $urandom}), i == extra - 1);
    endtask

    // unsolvable fast: row 0 full but for its last cell, whose digit sits below it
    function automatic void make_conflict(ref cell_t g[CELLS]);
        cell_t gone;
        gone = g[SIDE-1];
        g[SIDE-1] = '0;
        g[SIDE + SIDE-1] = gone;
    endfunction

    task automatic test_directed();
        cell_t g[CELLS];
        // empty grid: the search fills every cell itself
        for (int i = 0; i < CELLS; i++) g[i] = '0;
        send_grid(g);
        // full grid with an out-of-range given (all nibble bits set) and one blank
        make_solution(g);
        g[40] = 4'hf;
        g[$urandom_range(SIDE-1)] = '0;
        send_grid(g);
        // clashing givens: search gives up at once
        make_solution(g);
        make_conflict(g);
        send_grid(g);
        // too many rows: rows beyond the ninth are dropped, the last one starts the search
        make_solution(g);
        blank_cells(g, 20);
        send_grid(g, 2);
    endtask

    // short load: last_row on row 2, rows below keep the previous grid
    task automatic test_early_last();
        cell_t g[CELLS];
        make_solution(g);
        blank_cells(g, 15);
        send_grid(g);
        for (int r = 0; r < 3; r++) send_row(grid_row(g, r), r == 2);
    endtask

    task automatic test_random(int count);
        cell_t g[CELLS];
        int kind;
        for (int p = 0; p < count; p++) begin
            calm = (p >= count/2 && p < count/2 + 4);
            make_solution(g);
            kind = $urandom_range(99);
            if (kind < 75) begin
                blank_cells(g, $urandom_range(40));
                send_grid(g);
            end else if (kind < 85) begin
                make_conflict(g);
                blank_cells(g, $urandom_range(30));
                g[SIDE-1] = '0;
                send_grid(g);
            end else if (kind < 93) begin
                g[$urandom_range(CELLS-1)] = cell_t'($urandom_range(10, 15));
                blank_cells(g, $urandom_range(8));
                send_grid(g);
            end else begin
                blank_cells(g, $urandom_range(20));
                send_grid(g, $urandom_range(1, 3));
            end
        end
        calm = 1'b0;
    endtask

    // sender holds off until every outstanding result has drained
    task automatic test_drain_pause();
        cell_t g[CELLS];
        s_axis_tvalid <= 1'b0;
        while (solve_q.size() != 0) @(posedge aclk);
        make_solution(g);
        blank_cells(g, 30);
        send_grid(g);
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_early_last();
        test_drain_pause();
        test_random(30);
        test_drain_pause();
        s_axis_tvalid <= 1'b0;
        while (solve_q.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
        $display("%0d rows loaded into %0d puzzles (%0d with no solution), %0d result rows checked",
                 rows_sent, puzzles, unsolvable, rows_seen);
        if (errors == 0 && solve_q.size() == 0)
            $display("sudoku_backtracking_solver: match");
        else
            $display("sudoku_backtracking_solver: mismatch");
        $finish;
    end

    // guard against a hung search or handshake
    initial begin
        #200ms;
        $display("timeout with %0d results outstanding", solve_q.size());
        $display("sudoku_backtracking_solver: mismatch");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/sbs_pkg.sv
rtl/sbs_row_ram.sv
rtl/sudoku_backtracking_solver.sv
tb/tb_top.sv
